// ----- hdl/min_tracking_stack_defines.svh -----
// Assertion macros used by the min tracking stack top level.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define MTS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mts_pkg.sv -----
// Types and constants shared by the min tracking stack modules.
package mts_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 7;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STS_DONE  = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Committed stack operation, one strobe per kind.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_op_t;

  // Status of the value stack seen by the controller.
  typedef struct packed {
    logic full;
    logic empty;
    cnt_t count;
    cnt_t count_after;
  } vs_stat_t;

endpackage

// ----- hdl/mts_value_stack.sv -----
// Value stack: word memory with a registered read of the top entry, and its fill count.
module mts_value_stack import mts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     rd_en,
  input  stk_op_t  op,
  input  word_t    wr_value,
  output word_t    top_value,
  output vs_stat_t stat
);

  word_t mem [DEPTH];
  word_t top_q_r;
  cnt_t  count_r;
  cnt_t  count_nxt;
  cnt_t  top_idx;
  addr_t top_addr;
  addr_t wr_addr;

  assign top_idx  = count_r - CNT_W'(1);
  assign top_addr = top_idx[ADDR_W-1:0];
  assign wr_addr  = count_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[wr_addr] <= wr_value;
    end
    if (rd_en) begin
      top_q_r <= mem[top_addr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (op.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (op.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign top_value         = top_q_r;
  assign stat.full         = (count_r == CNT_W'(DEPTH));
  assign stat.empty        = (count_r == '0);
  assign stat.count        = count_r;
  assign stat.count_after  = count_nxt;

endmodule

// ----- hdl/mts_min_stack.sv -----
// Minimum stack: memory of running minima, two-port top read and push/pop decision.
module mts_min_stack import mts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    rd_en,
  input  stk_op_t op,
  input  word_t   push_value,
  input  word_t   popped_value,
  output word_t   min_after,
  output cnt_t    min_count
);

  word_t mem [DEPTH];
  word_t top_q_r;
  word_t below_q_r;
  cnt_t  count_r;
  cnt_t  count_nxt;
  cnt_t  top_idx;
  cnt_t  below_idx;
  logic  push_min;
  logic  pop_min;

  assign top_idx   = count_r - CNT_W'(1);
  assign below_idx = count_r - CNT_W'(2);

  // Push onto the minimum stack when it is empty or the new word does not exceed its top.
  assign push_min = op.push && (count_r != CNT_W'(DEPTH)) &&
                    ((count_r == '0) || (push_value <= top_q_r));
  // Drop the minimum when the word leaving the value stack is the minimum.
  assign pop_min  = op.pop && (count_r != '0) && (top_q_r == popped_value);

  always_ff @(posedge clk) begin
    if (push_min) begin
      mem[count_r[ADDR_W-1:0]] <= push_value;
    end
    if (rd_en) begin
      top_q_r   <= mem[top_idx[ADDR_W-1:0]];
      below_q_r <= mem[below_idx[ADDR_W-1:0]];
    end
  end

  always_comb begin
    count_nxt = count_r;
    min_after = '0;
    if (push_min) begin
      count_nxt = count_r + CNT_W'(1);
      min_after = push_value;
    end else if (pop_min) begin
      count_nxt = count_r - CNT_W'(1);
      if (count_r > CNT_W'(1)) begin
        min_after = below_q_r;
      end
    end else if (count_r != '0) begin
      min_after = top_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign min_count = count_r;

endmodule

// ----- hdl/min_tracking_stack.sv -----
// Top level of the min tracking stack: command sequencer, result register and checks.
//
// A LIFO of DEPTH (64) signed 32-bit words that reports the smallest value held after every
// operation. Each input item is a push (in_tuser = 0, word in in_tdata) or a pop
// (in_tuser = 1, in_tdata ignored), and each yields exactly one result item carrying the
// status, the popped word, the current minimum, a minimum-valid flag and the fill count.
// A push to a full stack and a pop from an empty one are refused with a status code and
// leave the stack unchanged. Both stacks live in synchronous memories with registered reads,
// so each item passes through ST_IDLE, which accepts it and reads the top entries at the
// current pointers, and ST_EXEC, which decides, writes back and loads the result register.
// Items are handled one at a time: the next is accepted only once the last has committed,
// and ST_EXEC holds while the result register is full and out_tready is low. The result
// register lets the next item be accepted and read while a finished result still waits on
// out_tready. No clearing pass is needed after reset: only entries below the fill counts are ever read.
`include "min_tracking_stack_defines.svh"

module min_tracking_stack import mts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] popped_value, [63:32] min_value, [70:64] count
  output logic [2:0]  out_tuser   // [1:0] status, [2] min_valid
);

  state_t   state_r;
  state_t   state_nxt;
  cmd_t     cmd_r;
  word_t    value_r;
  logic     accept;
  logic     out_free;
  logic     commit;
  stk_op_t  op;
  vs_stat_t vs_stat;
  word_t    vs_top;
  word_t    min_after;
  cnt_t     min_count;
  status_t  status_nxt;
  word_t    popped_nxt;

  // result register
  logic               out_tvalid_r;
  status_t            out_status_r;
  word_t              out_popped_r;
  word_t              out_min_r;
  logic               out_min_valid_r;
  logic [COUNT_W-1:0] out_count_r;

  // The result slot is free when empty or being drained this cycle.
  assign out_free = !out_tvalid_r || out_tready;
  assign accept   = in_tvalid && in_tready;

  // Next state: read tops on accept, commit once the result slot is free.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_EXEC: commit    = out_free;
      default: begin
        in_tready = 1'b0;
        commit    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the command while its tops are read.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= cmd_t'(in_tuser);
      value_r <= word_t'(in_tdata);
    end
  end

  // Decide the operation; refused commands change nothing.
  always_comb begin
    op.push    = commit && (cmd_r == CMD_PUSH) && !vs_stat.full;
    op.pop     = commit && (cmd_r == CMD_POP) && !vs_stat.empty;
    status_nxt = STS_DONE;
    if (cmd_r == CMD_PUSH && vs_stat.full) begin
      status_nxt = STS_FULL;
    end else if (cmd_r == CMD_POP && vs_stat.empty) begin
      status_nxt = STS_EMPTY;
    end
    popped_nxt = op.pop ? vs_top : '0;
  end

  mts_value_stack u_value_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .op        (op),
    .wr_value  (value_r),
    .top_value (vs_top),
    .stat      (vs_stat)
  );

  mts_min_stack u_min_stack (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_en        (accept),
    .op           (op),
    .push_value   (value_r),
    .popped_value (vs_top),
    .min_after    (min_after),
    .min_count    (min_count)
  );

  // Load the result on commit, drop the valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r    <= status_nxt;
      out_popped_r    <= popped_nxt;
      out_min_valid_r <= (vs_stat.count_after != '0);
      out_min_r       <= (vs_stat.count_after != '0) ? min_after : '0;
      out_count_r     <= COUNT_W'(vs_stat.count_after);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_count_r, out_min_r, out_popped_r};
  assign out_tuser  = {out_min_valid_r, out_status_r};

  // The minimum stack never outgrows the value stack, which never outgrows its store.
  `MTS_ASSERT_ALWAYS(a_min_le_value, min_count <= vs_stat.count, "min stack deeper than value stack")
  `MTS_ASSERT_ALWAYS(a_count_le_depth, vs_stat.count <= CNT_W'(DEPTH), "value count beyond depth")
  // A commit always leaves a result in the output register.
  `MTS_ASSERT_NEXT(a_commit_result, commit, out_tvalid_r, "commit without result")
  // Minimum and value stacks are empty together.
  `MTS_ASSERT_ALWAYS(a_empty_together, (min_count == '0) == vs_stat.empty, "stack emptiness mismatch")

endmodule

// ----- verif/min_tracking_stack_tb.sv -----
// Self-checking testbench for the min tracking stack: directed table, random push/pop runs.
module min_tracking_stack_tb import mts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1050;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_PRINTS  = 40;

  // One result item as the block should deliver it.
  typedef struct packed {
    status_t    status;
    word_t      popped;
    word_t      min_v;
    logic       min_ok;
    logic [6:0] count;
  } stack_result_t;

  // Directed row: an operation plus, where obvious, its expected result.
  typedef struct packed {
    cmd_t          cmd;
    word_t         value;
    bit            typed;
    stack_result_t res;
  } dir_row_t;

  // Shape of a random run of operations.
  typedef enum int {
    RUN_MIX,
    RUN_FILL,
    RUN_DRAIN
  } run_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic        in_tuser = 1'b0; // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // [31:0] popped_value, [63:32] min_value, [70:64] count
  logic [2:0]  out_tuser;       // [1:0] status, [2] min_valid

  // Predictor copy of both stacks.
  word_t         value_stack [DEPTH];
  word_t         min_stack   [DEPTH];
  int            n_values = 0;
  int            n_mins = 0;
  stack_result_t pending_results [$];

  int mismatches = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  int unsigned rx_cyc = 0;
  int stall_left = 0;

  dir_row_t dir_rows [23] = '{
    '{CMD_POP,  32'sd0,          1'b1, '{STS_EMPTY, 32'sd0, 32'sd0, 1'b0, 7'd0}},
    '{CMD_PUSH, 32'sh7FFF_FFFF,  1'b1, '{STS_DONE, 32'sd0, 32'sh7FFF_FFFF, 1'b1, 7'd1}},
    '{CMD_PUSH, 32'sh8000_0000,  1'b1, '{STS_DONE, 32'sd0, 32'sh8000_0000, 1'b1, 7'd2}},
    '{CMD_PUSH, 32'sh8000_0000,  1'b1, '{STS_DONE, 32'sd0, 32'sh8000_0000, 1'b1, 7'd3}},
    '{CMD_PUSH, 32'sd0,          1'b1, '{STS_DONE, 32'sd0, 32'sh8000_0000, 1'b1, 7'd4}},
    '{CMD_POP,  32'sd0,          1'b1, '{STS_DONE, 32'sd0, 32'sh8000_0000, 1'b1, 7'd3}},
    // duplicate of the minimum: the minimum must survive the first pop
    '{CMD_POP,  32'sd0,          1'b1,
      '{STS_DONE, 32'sh8000_0000, 32'sh8000_0000, 1'b1, 7'd2}},
    '{CMD_POP,  32'sd0,          1'b1,
      '{STS_DONE, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 7'd1}},
    '{CMD_POP,  32'sd0,          1'b1, '{STS_DONE, 32'sh7FFF_FFFF, 32'sd0, 1'b0, 7'd0}},
    '{CMD_POP,  32'sd0,          1'b1, '{STS_EMPTY, 32'sd0, 32'sd0, 1'b0, 7'd0}},
    '{CMD_PUSH, 32'sd5,          1'b0, '0},
    '{CMD_PUSH, -32'sd1,         1'b0, '0},
    '{CMD_PUSH, 32'sd7,          1'b0, '0},
    '{CMD_PUSH, -32'sd1,         1'b0, '0},
    '{CMD_PUSH, 32'sh5555_5555,  1'b0, '0},
    '{CMD_PUSH, 32'shAAAA_AAAA,  1'b0, '0},
    // pop with every value bit set: the word must be ignored
    '{CMD_POP,  32'shFFFF_FFFF,  1'b0, '0},
    '{CMD_POP,  32'sd0,          1'b0, '0},
    '{CMD_POP,  32'sd0,          1'b0, '0},
    '{CMD_POP,  32'sd0,          1'b0, '0},
    '{CMD_POP,  32'sd0,          1'b0, '0},
    '{CMD_POP,  32'sd0,          1'b0, '0},
    '{CMD_POP,  32'sd0,          1'b1, '{STS_EMPTY, 32'sd0, 32'sd0, 1'b0, 7'd0}}
  };

  min_tracking_stack i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Apply one operation to the predictor stacks and return the result it yields.
  function automatic stack_result_t apply_stack_op(cmd_t c, word_t v);
    stack_result_t r;
    r = '0;
    r.status = STS_DONE;
    if (c == CMD_PUSH) begin
      if (n_values >= DEPTH) begin
        r.status = STS_FULL;
      end else begin
        value_stack[n_values] = v;
        n_values++;
        // ties go on the minimum stack too, so duplicates are tracked
        if (n_mins == 0 || v <= min_stack[n_mins - 1]) begin
          min_stack[n_mins] = v;
          n_mins++;
        end
      end
    end else if (n_values == 0) begin
      r.status = STS_EMPTY;
    end else begin
      n_values--;
      r.popped = value_stack[n_values];
      if (n_mins > 0 && min_stack[n_mins - 1] == r.popped) n_mins--;
    end
    if (n_values > 0 && n_mins > 0) r.min_v = min_stack[n_mins - 1];
    r.min_ok = (n_values > 0);
    r.count  = n_values[6:0];
    return r;
  endfunction

  // Mix small values (many ties), extremes and full-range words.
  function automatic word_t pick_value();
    word_t v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = word_t'($urandom_range(0, 15)) - 32'sd8;
      4: begin
        case ($urandom_range(0, 3))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = 32'sd0;
          default: v = -32'sd1;
        endcase
      end
      default: v = word_t'($urandom);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
  endtask

  // Present one item, idling between bursts; on drain, hold off until all results are in.
  task automatic send_op(input cmd_t c, input word_t v, input bit typed,
                         input stack_result_t typed_res, input bit drain);
    stack_result_t r;
    int gap;
    if (burst_left == 0 || drain) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (drain && gap == 0) gap = 1;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        while (drain && pending_results.size() != 0) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_stack_op(c, v);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
    burst_left--;
  endtask

  // Receiver stall pattern: rotate through always ready, random, periodic and long stalls.
  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    case (rx_cyc[8:7])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (rx_cyc % 3 == 0);
      default: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 10);
        end
      end
    endcase
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, popped", out_tdata[31:0], 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser[1:0] !== want.status)
          report_mismatch("status", 32'(out_tuser[1:0]), 32'(want.status));
        if (out_tdata[31:0] !== want.popped)
          report_mismatch("popped_value", out_tdata[31:0], want.popped);
        if (out_tdata[63:32] !== want.min_v)
          report_mismatch("min_value", out_tdata[63:32], want.min_v);
        if (out_tuser[2] !== want.min_ok)
          report_mismatch("min_valid", 32'(out_tuser[2]), 32'(want.min_ok));
        if (out_tdata[70:64] !== want.count)
          report_mismatch("count", 32'(out_tdata[70:64]), 32'(want.count));
      end
    end
  end

  // Watchdog: end the run when neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    run_kind_t kind;
    int        run_len;
    int        push_pct;
    cmd_t      c;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_op(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res, 1'b0);

    // Fill past full, then drain past empty; hold off first until the table is done.
    send_op(CMD_PUSH, pick_value(), 1'b0, '0, 1'b1);
    repeat (DEPTH + 2) send_op(CMD_PUSH, pick_value(), 1'b0, '0, 1'b0);
    repeat (DEPTH + 3) send_op(CMD_POP, pick_value(), 1'b0, '0, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      kind    = run_kind_t'($urandom_range(0, 2));
      run_len = $urandom_range(10, 120);
      case (kind)
        RUN_FILL:  push_pct = 90;
        RUN_DRAIN: push_pct = 10;
        default:   push_pct = 50;
      endcase
      repeat (run_len) begin
        // stop the last run at the item target
        if (items_sent < ITEM_TARGET) begin
          c = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
          send_op(c, pick_value(), 1'b0, '0, $urandom_range(0, 149) == 0);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let any stray result show up
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mts_pkg.sv
hdl/mts_value_stack.sv
hdl/mts_min_stack.sv
hdl/min_tracking_stack.sv
verif/min_tracking_stack_tb.sv
